### design/cfhs_pkg.sv
// Package for the coarse/fine homing sequencer.
// Holds field widths, the phase and register index codes, and speed helpers.
// Used by the channel interfaces and by the top level.
package cfhs_pkg;

    localparam int SPEED_W     = 16;
    localparam int ANGLE_W     = 17;
    localparam int PHASE_W     = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;
    localparam logic signed [SPEED_W-1:0] SPEED_ZERO = '0;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE     = 3'd0,
        PH_BEGIN    = 3'd1,
        PH_COARSE   = 3'd2,
        PH_CFOUND   = 3'd3,
        PH_FINE     = 3'd4,
        PH_FFOUND   = 3'd5,
        PH_STEADY   = 3'd6,
        PH_COMPLETE = 3'd7
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COARSE_SPEED = 3'd0,
        REG_FINE_SPEED   = 3'd1,
        REG_COARSE_UPPER = 3'd2,
        REG_COARSE_LOWER = 3'd3,
        REG_FINE_UPPER   = 3'd4,
        REG_FINE_LOWER   = 3'd5
    } cfg_index_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_BEGIN = 1'b1
    } cmd_t;

    // Negation that saturates the most negative speed to the most positive one.
    function automatic logic signed [SPEED_W-1:0] neg_sat(
        input logic signed [SPEED_W-1:0] value
    );
        logic signed [SPEED_W-1:0] result;
        begin
            if (value == SPEED_MIN)
            begin
                result = SPEED_MAX;
            end
            else
            begin
                result = -value;
            end
            return result;
        end
    endfunction

endpackage

### design/cfhs_tick_if.sv
// Input channel of the homing sequencer: one tick or begin command per transfer.
// Depends on cfhs_pkg for field widths.
interface cfhs_tick_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   cmd;
    logic signed [cfhs_pkg::ANGLE_W-1:0]    angle;
    logic                                   sensor_now;
    logic                                   sensor_confirm;

    modport source (output valid, output cmd, output angle, output sensor_now,
                    output sensor_confirm, input ready);
    modport sink (input valid, input cmd, input angle, input sensor_now,
                  input sensor_confirm, output ready);
endinterface

### design/cfhs_result_if.sv
// Output channel of the homing sequencer: one result per transfer.
// Depends on cfhs_pkg for field widths.
interface cfhs_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cfhs_pkg::SPEED_W-1:0]    drive_speed;
    logic                                   position_reset;
    logic                                   complete;
    logic [cfhs_pkg::PHASE_W-1:0]           phase;

    modport source (output valid, output drive_speed, output position_reset,
                    output complete, output phase, input ready);
    modport sink (input valid, input drive_speed, input position_reset,
                  input complete, input phase, output ready);
endinterface

### design/coarse_fine_homing_sequencer_unit.sv
// Top level of the coarse/fine homing sequencer.
// Depends on cfhs_pkg, cfhs_tick_if and cfhs_result_if.
//
// Usage: each transfer on the tick channel carries a command (tick or begin),
// the motor angle and two samples of the active-low home sensor. For every
// transfer the result channel delivers exactly one result: the drive speed,
// a position reset pulse, the complete flag and the phase after the step.
// The six setup registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no tick is in flight, which the block
// itself does not enforce. Writes to unused indexes are ignored.
// A tick is captured in an input register; when it advances, the phase and
// speed registers update and the result register loads. One tick can be
// taken in every cycle while the result channel keeps up.
// When the receiver stalls, the result register holds and one more tick can
// wait in the input register; after that the tick channel drops ready.
// Reset clears the phase to idle, the speed and all setup registers to zero
// and empties both registers.
module coarse_fine_homing_sequencer_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    cfhs_tick_if.sink                               tick,
    cfhs_result_if.source                           result,
    input  logic                                    cfg_we,
    input  logic [cfhs_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [cfhs_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic signed [cfhs_pkg::SPEED_W-1:0] coarse_speed_reg;
    logic signed [cfhs_pkg::SPEED_W-1:0] fine_speed_reg;
    logic signed [cfhs_pkg::ANGLE_W-1:0] coarse_upper_reg;
    logic signed [cfhs_pkg::ANGLE_W-1:0] coarse_lower_reg;
    logic signed [cfhs_pkg::ANGLE_W-1:0] fine_upper_reg;
    logic signed [cfhs_pkg::ANGLE_W-1:0] fine_lower_reg;

    logic                                s1_valid_reg;
    logic                                s1_cmd_reg;
    logic signed [cfhs_pkg::ANGLE_W-1:0] s1_angle_reg;
    logic                                s1_now_reg;
    logic                                s1_confirm_reg;

    cfhs_pkg::phase_t                    phase_reg;
    cfhs_pkg::phase_t                    phase_next;
    logic signed [cfhs_pkg::SPEED_W-1:0] speed_reg;
    logic signed [cfhs_pkg::SPEED_W-1:0] speed_next;

    logic                                out_valid_reg;
    logic signed [cfhs_pkg::SPEED_W-1:0] out_speed_reg;
    logic                                out_prst_reg;
    logic                                out_complete_reg;
    cfhs_pkg::phase_t                    out_phase_reg;

    logic                                prst_next;
    logic                                advance;
    logic                                now_det;
    logic                                conf_det;
    logic                                confirmed;
    logic signed [cfhs_pkg::ANGLE_W-1:0] sweep_upper;
    logic signed [cfhs_pkg::ANGLE_W-1:0] sweep_lower;
    logic signed [cfhs_pkg::SPEED_W-1:0] swept_speed;

    assign advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready  = !s1_valid_reg || advance;

    // Setup registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coarse_speed_reg <= '0;
            fine_speed_reg   <= '0;
            coarse_upper_reg <= '0;
            coarse_lower_reg <= '0;
            fine_upper_reg   <= '0;
            fine_lower_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cfhs_pkg::REG_COARSE_SPEED: coarse_speed_reg <= cfg_data[cfhs_pkg::SPEED_W-1:0];
                cfhs_pkg::REG_FINE_SPEED:   fine_speed_reg   <= cfg_data[cfhs_pkg::SPEED_W-1:0];
                cfhs_pkg::REG_COARSE_UPPER: coarse_upper_reg <= cfg_data[cfhs_pkg::ANGLE_W-1:0];
                cfhs_pkg::REG_COARSE_LOWER: coarse_lower_reg <= cfg_data[cfhs_pkg::ANGLE_W-1:0];
                cfhs_pkg::REG_FINE_UPPER:   fine_upper_reg   <= cfg_data[cfhs_pkg::ANGLE_W-1:0];
                cfhs_pkg::REG_FINE_LOWER:   fine_lower_reg   <= cfg_data[cfhs_pkg::ANGLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            s1_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s1_cmd_reg     <= tick.cmd;
            s1_angle_reg   <= tick.angle;
            s1_now_reg     <= tick.sensor_now;
            s1_confirm_reg <= tick.sensor_confirm;
        end
    end

    assign now_det   = !s1_now_reg;
    assign conf_det  = !s1_confirm_reg;
    assign confirmed = now_det && conf_det;

    // Reversal at the sweep limits; the limits follow the current phase.
    always_comb
    begin
        if (phase_reg == cfhs_pkg::PH_FINE)
        begin
            sweep_upper = fine_upper_reg;
            sweep_lower = fine_lower_reg;
        end
        else
        begin
            sweep_upper = coarse_upper_reg;
            sweep_lower = coarse_lower_reg;
        end
        priority if (s1_angle_reg > sweep_upper && speed_reg > cfhs_pkg::SPEED_ZERO)
        begin
            swept_speed = cfhs_pkg::neg_sat(speed_reg);
        end
        else if (s1_angle_reg < sweep_lower && speed_reg < cfhs_pkg::SPEED_ZERO)
        begin
            swept_speed = cfhs_pkg::neg_sat(speed_reg);
        end
        else
        begin
            swept_speed = speed_reg;
        end
    end

    // Next phase and speed.
    always_comb
    begin
        phase_next = phase_reg;
        speed_next = speed_reg;
        if (s1_cmd_reg == cfhs_pkg::CMD_BEGIN)
        begin
            phase_next = cfhs_pkg::PH_BEGIN;
        end
        else
        begin
            unique case (phase_reg)
                cfhs_pkg::PH_BEGIN:
                begin
                    if (!now_det)
                    begin
                        speed_next = coarse_speed_reg;
                        phase_next = cfhs_pkg::PH_COARSE;
                    end
                    else if (conf_det)
                    begin
                        phase_next = cfhs_pkg::PH_COMPLETE;
                    end
                end
                cfhs_pkg::PH_COARSE:
                begin
                    speed_next = swept_speed;
                    if (confirmed)
                    begin
                        speed_next = fine_speed_reg;
                        phase_next = cfhs_pkg::PH_CFOUND;
                    end
                end
                cfhs_pkg::PH_CFOUND:
                begin
                    phase_next = cfhs_pkg::PH_FINE;
                end
                cfhs_pkg::PH_FINE:
                begin
                    speed_next = swept_speed;
                    if (confirmed)
                    begin
                        speed_next = cfhs_pkg::SPEED_ZERO;
                        phase_next = cfhs_pkg::PH_FFOUND;
                    end
                end
                cfhs_pkg::PH_FFOUND:
                begin
                    phase_next = cfhs_pkg::PH_STEADY;
                end
                cfhs_pkg::PH_STEADY:
                begin
                    phase_next = cfhs_pkg::PH_COMPLETE;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Position reset pulses on the step that leaves either found phase.
    always_comb
    begin
        prst_next = (s1_cmd_reg == cfhs_pkg::CMD_TICK)
                    && (phase_reg == cfhs_pkg::PH_CFOUND || phase_reg == cfhs_pkg::PH_FFOUND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfhs_pkg::PH_IDLE;
            speed_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            speed_reg <= speed_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_speed_reg    <= speed_next;
            out_prst_reg     <= prst_next;
            out_complete_reg <= (phase_next == cfhs_pkg::PH_COMPLETE);
            out_phase_reg    <= phase_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.drive_speed    = out_speed_reg;
    assign result.position_reset = out_prst_reg;
    assign result.complete       = out_complete_reg;
    assign result.phase          = out_phase_reg;

    // A position reset is only reported on entry to the fine or steady phase.
    a_prst_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_prst_reg)
            |-> (out_phase_reg == cfhs_pkg::PH_FINE || out_phase_reg == cfhs_pkg::PH_STEADY))
        else $error("position reset outside a found phase exit");

    // The drive is stopped from the fine found phase until a restart.
    a_stop_after_fine: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == cfhs_pkg::PH_FFOUND || phase_reg == cfhs_pkg::PH_STEADY)
            |-> (speed_reg == cfhs_pkg::SPEED_ZERO))
        else $error("drive speed not zero after fine search");

    // Idle is left only through a begin command.
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_cmd_reg == cfhs_pkg::CMD_TICK && phase_reg == cfhs_pkg::PH_IDLE)
            |=> (phase_reg == cfhs_pkg::PH_IDLE))
        else $error("idle phase left without a begin command");

    // A held result keeps the sequencer state unchanged.
    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready)
            |=> ($stable(phase_reg) && $stable(speed_reg)))
        else $error("sequencer state moved while result was stalled");

endmodule

### sim/tb_coarse_fine_homing_sequencer_unit.sv
// Testbench for the coarse/fine homing sequencer top level.
// Drives ticks and setup writes, predicts every result and checks it field by field.
// Depends on cfhs_pkg, cfhs_tick_if, cfhs_result_if and coarse_fine_homing_sequencer_unit.
module tb_coarse_fine_homing_sequencer_unit;

    typedef struct packed {
        logic signed [cfhs_pkg::SPEED_W-1:0] speed;
        logic                                prst;
        logic                                done;
        cfhs_pkg::phase_t                    phase;
    } homing_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [cfhs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cfhs_pkg::CFG_DATA_W-1:0] cfg_data;

    cfhs_tick_if tick_ch();
    cfhs_result_if result_ch();

    coarse_fine_homing_sequencer_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .tick(tick_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    homing_result_t expected_results[$];

    cfhs_pkg::phase_t model_phase;
    logic signed [cfhs_pkg::SPEED_W-1:0] model_speed;
    logic signed [cfhs_pkg::SPEED_W-1:0] cfg_coarse_speed;
    logic signed [cfhs_pkg::SPEED_W-1:0] cfg_fine_speed;
    logic signed [cfhs_pkg::ANGLE_W-1:0] cfg_coarse_upper;
    logic signed [cfhs_pkg::ANGLE_W-1:0] cfg_coarse_lower;
    logic signed [cfhs_pkg::ANGLE_W-1:0] cfg_fine_upper;
    logic signed [cfhs_pkg::ANGLE_W-1:0] cfg_fine_lower;

    bit idle_enable;
    int stall_left;
    int fail_count;
    int tick_count;
    int result_count;
    int setting_count;
    int homing_done;
    int reset_pulses;

    always #10 clk = ~clk;

    function automatic logic signed [cfhs_pkg::SPEED_W-1:0] reversed_speed(
        input logic signed [cfhs_pkg::ANGLE_W-1:0] ang,
        input logic signed [cfhs_pkg::ANGLE_W-1:0] upper,
        input logic signed [cfhs_pkg::ANGLE_W-1:0] lower,
        input logic signed [cfhs_pkg::SPEED_W-1:0] spd
    );
        logic flip;
        flip = (ang > upper && spd > 0) || (ang < lower && spd < 0);
        if (!flip)
        begin
            return spd;
        end
        else if (spd == cfhs_pkg::SPEED_MIN)
        begin
            return cfhs_pkg::SPEED_MAX;
        end
        else
        begin
            return -spd;
        end
    endfunction

    function automatic homing_result_t predict_step(
        input cfhs_pkg::cmd_t cmd,
        input logic signed [cfhs_pkg::ANGLE_W-1:0] ang,
        input logic now_lvl,
        input logic conf_lvl
    );
        homing_result_t r;
        logic confirmed;
        confirmed = !now_lvl && !conf_lvl;
        r.prst = 1'b0;
        if (cmd == cfhs_pkg::CMD_BEGIN)
        begin
            model_phase = cfhs_pkg::PH_BEGIN;
        end
        else
        begin
            case (model_phase)
                cfhs_pkg::PH_BEGIN:
                begin
                    if (now_lvl)
                    begin
                        model_speed = cfg_coarse_speed;
                        model_phase = cfhs_pkg::PH_COARSE;
                    end
                    else if (!conf_lvl)
                    begin
                        model_phase = cfhs_pkg::PH_COMPLETE;
                    end
                end
                cfhs_pkg::PH_COARSE:
                begin
                    model_speed = reversed_speed(ang, cfg_coarse_upper, cfg_coarse_lower,
                                                 model_speed);
                    if (confirmed)
                    begin
                        model_speed = cfg_fine_speed;
                        model_phase = cfhs_pkg::PH_CFOUND;
                    end
                end
                cfhs_pkg::PH_CFOUND:
                begin
                    r.prst = 1'b1;
                    model_phase = cfhs_pkg::PH_FINE;
                end
                cfhs_pkg::PH_FINE:
                begin
                    model_speed = reversed_speed(ang, cfg_fine_upper, cfg_fine_lower,
                                                 model_speed);
                    if (confirmed)
                    begin
                        model_speed = cfhs_pkg::SPEED_ZERO;
                        model_phase = cfhs_pkg::PH_FFOUND;
                    end
                end
                cfhs_pkg::PH_FFOUND:
                begin
                    r.prst = 1'b1;
                    model_phase = cfhs_pkg::PH_STEADY;
                end
                cfhs_pkg::PH_STEADY:
                begin
                    model_phase = cfhs_pkg::PH_COMPLETE;
                end
                default:
                begin
                end
            endcase
        end
        r.speed = model_speed;
        r.done = (model_phase == cfhs_pkg::PH_COMPLETE);
        r.phase = model_phase;
        return r;
    endfunction

    task automatic send_tick(input cfhs_pkg::cmd_t cmd, input int ang, input logic now_lvl,
                             input logic conf_lvl);
        int gap;
        cfhs_pkg::phase_t was;
        homing_result_t want;
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 16);
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.cmd <= cmd;
        tick_ch.angle <= ang[cfhs_pkg::ANGLE_W-1:0];
        tick_ch.sensor_now <= now_lvl;
        tick_ch.sensor_confirm <= conf_lvl;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        was = model_phase;
        want = predict_step(cmd, ang[cfhs_pkg::ANGLE_W-1:0], now_lvl, conf_lvl);
        expected_results.push_back(want);
        tick_count++;
        if (want.prst)
        begin
            reset_pulses++;
        end
        if (want.phase == cfhs_pkg::PH_COMPLETE && was != cfhs_pkg::PH_COMPLETE)
        begin
            homing_done++;
        end
    endtask

    task automatic wait_results_drained();
        tick_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input cfhs_pkg::cfg_index_t idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[cfhs_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            cfhs_pkg::REG_COARSE_SPEED: cfg_coarse_speed = value[cfhs_pkg::SPEED_W-1:0];
            cfhs_pkg::REG_FINE_SPEED:   cfg_fine_speed = value[cfhs_pkg::SPEED_W-1:0];
            cfhs_pkg::REG_COARSE_UPPER: cfg_coarse_upper = value[cfhs_pkg::ANGLE_W-1:0];
            cfhs_pkg::REG_COARSE_LOWER: cfg_coarse_lower = value[cfhs_pkg::ANGLE_W-1:0];
            cfhs_pkg::REG_FINE_UPPER:   cfg_fine_upper = value[cfhs_pkg::ANGLE_W-1:0];
            cfhs_pkg::REG_FINE_LOWER:   cfg_fine_lower = value[cfhs_pkg::ANGLE_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic program_setup(input int cs, input int fs, input int cu, input int cl,
                                 input int fu, input int fl);
        wait_results_drained();
        write_register(cfhs_pkg::REG_COARSE_SPEED, cs);
        write_register(cfhs_pkg::REG_FINE_SPEED, fs);
        write_register(cfhs_pkg::REG_COARSE_UPPER, cu);
        write_register(cfhs_pkg::REG_COARSE_LOWER, cl);
        write_register(cfhs_pkg::REG_FINE_UPPER, fu);
        write_register(cfhs_pkg::REG_FINE_LOWER, fl);
        setting_count++;
    endtask

    function automatic int pick_speed();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int pick_bound();
        case ($urandom_range(0, 7))
            0: return -36000;
            1: return 36000;
            2: return 0;
            default: return int'($urandom_range(0, 72000)) - 36000;
        endcase
    endfunction

    function automatic int pick_angle();
        int ang;
        if ($urandom_range(0, 1) == 0)
        begin
            return int'($urandom_range(0, 72000)) - 36000;
        end
        case ($urandom_range(0, 3))
            0: ang = int'(cfg_coarse_upper);
            1: ang = int'(cfg_coarse_lower);
            2: ang = int'(cfg_fine_upper);
            default: ang = int'(cfg_fine_lower);
        endcase
        ang = ang + int'($urandom_range(0, 4)) - 2;
        if (ang > 36000)
        begin
            ang = 36000;
        end
        if (ang < -36000)
        begin
            ang = -36000;
        end
        return ang;
    endfunction

    task automatic test_idle_and_instant_home();
        program_setup(256, -64, 1000, -1000, 200, -200);
        send_tick(cfhs_pkg::CMD_TICK, 36000, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, -36000, 1'b0, 1'b0);
        send_tick(cfhs_pkg::CMD_BEGIN, 0, 1'b0, 1'b0);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b0, 1'b0);
        send_tick(cfhs_pkg::CMD_TICK, 5, 1'b1, 1'b1);
    endtask

    task automatic test_full_sequence();
        send_tick(cfhs_pkg::CMD_BEGIN, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b0, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 36000, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, -36000, 1'b1, 1'b0);
        send_tick(cfhs_pkg::CMD_TICK, 1000, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 2000, 1'b0, 1'b0);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, -36000, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b1, 1'b0);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b0, 1'b0);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b1, 1'b1);
    endtask

    task automatic test_restart();
        send_tick(cfhs_pkg::CMD_BEGIN, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_BEGIN, 0, 1'b1, 1'b1);
    endtask

    task automatic test_saturation_and_zero_speed();
        program_setup(-32768, 0, 36000, 0, -36000, 36000);
        send_tick(cfhs_pkg::CMD_BEGIN, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, -1, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 36000, 1'b0, 1'b0);
        send_tick(cfhs_pkg::CMD_TICK, 0, 1'b1, 1'b1);
        send_tick(cfhs_pkg::CMD_TICK, 36000, 1'b1, 1'b1);
    endtask

    task automatic test_random_homing(input int settings, input int items_each);
        int r;
        int s;
        cfhs_pkg::cmd_t cmd;
        logic now_lvl;
        logic conf_lvl;
        for (int k = 0; k < settings; k++)
        begin
            program_setup(pick_speed(), pick_speed(), pick_bound(), pick_bound(),
                          pick_bound(), pick_bound());
            if (k == settings - 1)
            begin
                idle_enable = 1'b0;
            end
            for (int n = 0; n < items_each; n++)
            begin
                r = $urandom_range(0, 99);
                if (model_phase == cfhs_pkg::PH_IDLE || model_phase == cfhs_pkg::PH_COMPLETE)
                begin
                    cmd = (r < 70) ? cfhs_pkg::CMD_BEGIN : cfhs_pkg::CMD_TICK;
                end
                else
                begin
                    cmd = (r < 3) ? cfhs_pkg::CMD_BEGIN : cfhs_pkg::CMD_TICK;
                end
                s = $urandom_range(0, 11);
                now_lvl = (s > 1);
                conf_lvl = !(s == 0 || s == 2);
                send_tick(cmd, pick_angle(), now_lvl, conf_lvl);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        homing_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                $error("Result transfer arrived with no expected result pending.");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.drive_speed !== want.speed)
                begin
                    $error("drive_speed mismatch: expected %0d, actual %0d",
                           $signed(want.speed), result_ch.drive_speed);
                    fail_count++;
                end
                if (result_ch.position_reset !== want.prst)
                begin
                    $error("position_reset mismatch: expected %0d, actual %0d",
                           want.prst, result_ch.position_reset);
                    fail_count++;
                end
                if (result_ch.complete !== want.done)
                begin
                    $error("complete mismatch: expected %0d, actual %0d",
                           want.done, result_ch.complete);
                    fail_count++;
                end
                if (result_ch.phase !== want.phase)
                begin
                    $error("phase mismatch: expected %0d, actual %0d",
                           want.phase, result_ch.phase);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.cmd = cfhs_pkg::CMD_TICK;
        tick_ch.angle = '0;
        tick_ch.sensor_now = 1'b1;
        tick_ch.sensor_confirm = 1'b1;
        model_phase = cfhs_pkg::PH_IDLE;
        model_speed = cfhs_pkg::SPEED_ZERO;
        cfg_coarse_speed = '0;
        cfg_fine_speed = '0;
        cfg_coarse_upper = '0;
        cfg_coarse_lower = '0;
        cfg_fine_upper = '0;
        cfg_fine_lower = '0;
        idle_enable = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_instant_home();
        test_full_sequence();
        test_restart();
        test_saturation_and_zero_speed();
        test_random_homing(6, 237);

        wait_results_drained();
        $display("Checked %0d results from %0d ticks over %0d register settings.",
                 result_count, tick_count, setting_count);
        $display("The run saw %0d position reset pulses and %0d completed homings.",
                 reset_pulses, homing_done);
        if (fail_count == 0)
        begin
            $display("PASS coarse_fine_homing_sequencer_unit");
        end
        else
        begin
            $display("FAIL coarse_fine_homing_sequencer_unit");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timed out waiting for transfers to complete.");
        $display("FAIL coarse_fine_homing_sequencer_unit");
        $finish;
    end

endmodule
